>>> rtl/shch_pkg.sv
// Shared types and constants of the single-hit channel histogrammer.
// Used by the channel interfaces, the divider and the top level; no dependencies.
package shch_pkg;

  // Parameter defaults
  localparam int CHANNELS_DEF   = 25;
  localparam int BINS_DEF       = 256;
  localparam int ADC_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF = 32;

  // Field widths fixed by the item format
  localparam int CHAN_W    = 5;
  localparam int ADC_W     = 16;
  localparam int BIN_W     = 8;
  localparam int HITS_W    = 5;
  localparam int VALUE_W   = 32;
  localparam int CUT_W     = 16;
  localparam int LOW_W     = 16;
  localparam int WIDTH_W   = 13;
  localparam int NBINS_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int COUNT_MAX_W = 48;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_CUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd3;

  // Register reset values
  localparam logic [CUT_W-1:0]   ENERGY_CUT_RST  = 16'd2000;
  localparam logic [LOW_W-1:0]   HIST_LOW_RST    = 16'd4000;
  localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST   = 13'd50;
  localparam logic [NBINS_W-1:0] BINS_IN_USE_RST = 8'd200;

  // Item codes
  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_READ    = 1'b1;
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  localparam logic [HITS_W-1:0] HITS_MAX = 5'd31;

  typedef struct packed {
    logic              mode;
    logic [CHAN_W-1:0] channel;
    logic [ADC_W-1:0]  peak;
    logic [ADC_W-1:0]  pedestal;
    logic              last_in_event;
    logic [BIN_W-1:0]  read_bin;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic               accepted;
    logic               filled;
    logic [CHAN_W-1:0]  hit_channel;
    logic [HITS_W-1:0]  hit_total;
    logic [BIN_W-1:0]   filled_bin;
    logic [VALUE_W-1:0] bin_value;
  } out_item_t;

endpackage

>>> rtl/shch_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on shch_pkg for the payload types.
interface shch_in_if;
  logic               valid;
  logic               ready;
  shch_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface shch_out_if;
  logic                valid;
  logic                ready;
  shch_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/shch_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module shch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 6400
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/shch_div.sv
// Restoring divider, one quotient bit per cycle, for the bin index.
// Depends on shch_pkg for the divisor and quotient widths.
module shch_div #(
  parameter int NUM_W = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [NUM_W-1:0]                  num,
  input  logic [shch_pkg::WIDTH_W-1:0]      den,
  output logic                              done,
  output logic [shch_pkg::BIN_W-1:0]        quo
);

  localparam int QW = shch_pkg::BIN_W;
  localparam int DW = shch_pkg::WIDTH_W;
  localparam int CW = (NUM_W > DW + QW) ? NUM_W : DW + QW;
  localparam int SW = $clog2(QW);

  logic          busy;
  logic [SW-1:0] step;
  logic [CW-1:0] rem;
  logic [CW-1:0] dsh;
  logic          fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= SW'(QW - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step - SW'(1);
      end
    end
  end

  // Caller keeps the dividend below 2^QW times the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CW'(num);
      dsh <= CW'(den) << (QW - 1);
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QW-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done held for more than one cycle");

endmodule

>>> rtl/single_hit_channel_histogrammer.sv
// Single-hit channel histogrammer: one calorimeter sample per input beat; the last sample of
// an event produces a verdict beat and, for a single hit inside the window, a saturating bin
// increment in that channel's histogram. A read beat returns one bin count. After reset the
// histogram RAM is zeroed one entry per cycle, CHANNELS*BINS entries (6400 by default), with
// input ready low; configuration writes are taken throughout. An event end with a fill in
// the window reads and then increments the bin; a regular fill first finds the bin with the
// divider, an underflow fill uses bin 0. A read beat goes through the RAM's registered read
// port. A finished result waits in an output register, so the next beat is taken while it is
// held.
// Depends on shch_pkg, shch_if, shch_ram and shch_div.
module single_hit_channel_histogrammer #(
  parameter int CHANNELS   = shch_pkg::CHANNELS_DEF,
  parameter int BINS       = shch_pkg::BINS_DEF,
  parameter int ADC_BITS   = shch_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = shch_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [shch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [shch_pkg::CFG_W-1:0]        cfg_data,
  shch_in_if.sink                           item,
  shch_out_if.source                        result
);

  localparam int DEPTH  = CHANNELS * BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int VW     = ((ADC_BITS > shch_pkg::ADC_W) ? ADC_BITS : shch_pkg::ADC_W) + 10;
  localparam int PROD_W = shch_pkg::NBINS_W + 1 + shch_pkg::WIDTH_W;
  localparam logic [VW-1:0] ADC_MASK = VW'((64'd1 << ADC_BITS) - 64'd1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_WIN   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_INC   = 4'd6;
  localparam logic [3:0] S_VERD  = 4'd7;
  localparam logic [3:0] S_RQ    = 4'd8;
  localparam logic [3:0] S_ROUT  = 4'd9;

  // Configuration
  logic [shch_pkg::CUT_W-1:0]   energy_cut;
  logic [shch_pkg::LOW_W-1:0]   hist_low;
  logic [shch_pkg::WIDTH_W-1:0] bin_width;
  logic [shch_pkg::NBINS_W-1:0] bins_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_cut  <= shch_pkg::ENERGY_CUT_RST;
      hist_low    <= shch_pkg::HIST_LOW_RST;
      bin_width   <= shch_pkg::BIN_WIDTH_RST;
      bins_in_use <= shch_pkg::BINS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        shch_pkg::REG_ENERGY_CUT:  energy_cut  <= cfg_data[shch_pkg::CUT_W-1:0];
        shch_pkg::REG_HIST_LOW:    hist_low    <= cfg_data[shch_pkg::LOW_W-1:0];
        shch_pkg::REG_BIN_WIDTH:   bin_width   <= cfg_data[shch_pkg::WIDTH_W-1:0];
        shch_pkg::REG_BINS_IN_USE: bins_in_use <= cfg_data[shch_pkg::NBINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and event state
  logic [3:0]                    state;
  logic [ADDR_W-1:0]             clr_addr;
  shch_pkg::in_item_t            item_q;
  logic [shch_pkg::HITS_W-1:0]   hits;
  logic [shch_pkg::CHAN_W-1:0]   hit_chan;
  logic [ADC_BITS-1:0]           hit_amp;
  logic [PROD_W-1:0]             prod;
  logic                          fill_q;
  logic [shch_pkg::BIN_W-1:0]    fbin;
  shch_pkg::out_item_t           res_q;
  logic                          res_valid;

  // Datapath
  logic [VW-1:0]                 pk;
  logic [VW-1:0]                 pd;
  logic                          chan_ok;
  logic                          is_hit;
  logic [shch_pkg::NBINS_W-1:0]  n_eff;
  logic                          acc;
  logic [VW-1:0]                 two_amp;
  logic [VW-1:0]                 two_lo;
  logic                          in_window;
  logic                          below_low;
  logic [VW-1:0]                 offset;
  logic                          out_free;
  logic                          res_load;
  logic                          rd_ok;
  logic                          div_start;
  logic                          div_done;
  logic [shch_pkg::BIN_W-1:0]    div_quo;

  // RAM port
  logic [ADDR_W-1:0]             ram_addr;
  logic                          ram_we;
  logic [COUNT_BITS-1:0]         ram_wdata;
  logic [COUNT_BITS-1:0]         ram_rdata;
  logic [shch_pkg::COUNT_MAX_W-1:0] count_wide;

  assign pk      = VW'(item_q.peak) & ADC_MASK;
  assign pd      = VW'(item_q.pedestal) & ADC_MASK;
  assign chan_ok = (7'(item_q.channel) < 7'(CHANNELS));
  assign is_hit  = chan_ok && (pk > pd + VW'(energy_cut));

  assign n_eff = (11'(bins_in_use) > 11'(BINS - 1)) ? shch_pkg::NBINS_W'(BINS - 1)
                                                    : bins_in_use;
  assign acc       = (hits == shch_pkg::HITS_W'(1));
  assign two_amp   = VW'(hit_amp) << 1;
  assign two_lo    = VW'(hist_low) << 1;
  // L - W/2 < amp < L + (N - 1/2) * W, doubled
  assign in_window = acc && (bin_width != '0) && (n_eff != '0)
                     && (two_amp + VW'(bin_width) > two_lo)
                     && (two_amp < two_lo + VW'(prod));
  assign below_low = (VW'(hit_amp) < VW'(hist_low));
  assign offset    = VW'(hit_amp) - VW'(hist_low);
  assign div_start = (state == S_WIN) && in_window && !below_low;

  assign rd_ok    = chan_ok && (11'(item_q.read_bin) < 11'(BINS));
  assign out_free = !res_valid || result.ready;
  assign res_load = ((state == S_VERD) || (state == S_ROUT)) && out_free;

  shch_div #(.NUM_W(ADC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (offset[ADC_BITS-1:0]),
    .den   (bin_width),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = ADDR_W'(int'(hit_chan) * BINS + int'(fbin));
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      S_INC: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
      end
      // hold the read address while the readout waits for the output register
      S_RQ, S_ROUT: begin
        ram_addr = ADDR_W'(int'(item_q.channel) * BINS + int'(item_q.read_bin));
      end
      default: ;
    endcase
  end

  shch_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign count_wide = shch_pkg::COUNT_MAX_W'(ram_rdata);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      hits      <= '0;
      hit_chan  <= '0;
      hit_amp   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item.valid) begin
            item_q <= item.data;
            state  <= (item.data.mode == shch_pkg::MODE_READ) ? S_RQ : S_EVAL;
          end
        end
        S_EVAL: begin
          if (is_hit) begin
            if (hits != shch_pkg::HITS_MAX) begin
              hits <= hits + shch_pkg::HITS_W'(1);
            end
            hit_chan <= item_q.channel;
            hit_amp  <= ADC_BITS'(pk - pd);
          end
          prod  <= PROD_W'(({1'b0, n_eff, 1'b0} - 10'd1)) * PROD_W'(bin_width);
          state <= item_q.last_in_event ? S_WIN : S_IDLE;
        end
        S_WIN: begin
          fill_q <= in_window;
          fbin   <= '0;
          if (!in_window) begin
            state <= S_VERD;
          end else if (below_low) begin
            state <= S_RD;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            fbin  <= div_quo + shch_pkg::BIN_W'(1);
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_INC;
        end
        S_INC: begin
          state <= S_VERD;
        end
        S_VERD: begin
          if (out_free) begin
            res_q.kind        <= shch_pkg::KIND_VERDICT;
            res_q.accepted    <= acc;
            res_q.filled      <= fill_q;
            res_q.hit_channel <= acc ? hit_chan : '0;
            res_q.hit_total   <= hits;
            res_q.filled_bin  <= fill_q ? fbin : '0;
            res_q.bin_value   <= '0;
            hits     <= '0;
            hit_chan <= '0;
            hit_amp  <= '0;
            state    <= S_IDLE;
          end
        end
        S_RQ: begin
          state <= S_ROUT;
        end
        S_ROUT: begin
          if (out_free) begin
            res_q.kind        <= shch_pkg::KIND_READOUT;
            res_q.accepted    <= 1'b0;
            res_q.filled      <= 1'b0;
            res_q.hit_channel <= '0;
            res_q.hit_total   <= '0;
            res_q.filled_bin  <= '0;
            if (!rd_ok) begin
              res_q.bin_value <= '0;
            end else if (count_wide > shch_pkg::COUNT_MAX_W'(32'hFFFF_FFFF)) begin
              res_q.bin_value <= '1;
            end else begin
              res_q.bin_value <= count_wide[shch_pkg::VALUE_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item.ready   = (state == S_IDLE);
  assign result.valid = res_valid;
  assign result.data  = res_q;

  a_fill_single_hit: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_q.filled |-> res_q.accepted && res_q.hit_total == shch_pkg::HITS_W'(1))
    else $error("bin filled without a single hit");

  a_readout_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_q.kind == shch_pkg::KIND_READOUT
      |-> !res_q.accepted && !res_q.filled && res_q.hit_total == '0)
    else $error("readout beat carries verdict fields");

  a_div_in_seq: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_ram_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_CLEAR || state == S_INC)
    else $error("unexpected histogram write");

  a_inc_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_INC |-> $past(state) == S_RD)
    else $error("bin increment without a preceding read");

endmodule
